>>> hdl/msp_pkg.sv
// Shared types and constants for the multistage graph shortest path unit.
// Holds operation codes, fixed field widths and the result word layout.
// No dependencies.
`default_nettype none

package msp_pkg;

    localparam int OP_W     = 2;
    localparam int VIDX_W   = 4;
    localparam int WFIELD_W = 16;
    localparam int COST_W   = 20;
    localparam int VCOUNT_W = 5;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic [COST_W-1:0]   COST_FIELD_MAX = 20'hFFFFF;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET   = 5'd8;

    typedef struct packed {
        logic [VIDX_W-1:0] path_vertex;
        logic [COST_W-1:0] total_cost;
        logic              reachable;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/multistage_graph_shortest_path_unit.sv
// Multistage graph shortest path unit: edge matrix, backward DP and path walk.
// Depends on msp_pkg, msp_edge_store and msp_vertex_store.
//
// Usage:
//   Item channel (item_valid/item_stall): operation, from_vertex, to_vertex,
//   weight. Edge write and remove words give no result; a compute word runs
//   the DP and then emits the path.
//   Result channel (result_valid/result_stall): one word per path vertex from
//   vertex 0 to the sink, last set on the final word; a single word with
//   reachable clear when no path exists.
//   Config channel (cfg_valid/cfg_ready): vertex_count, always ready; write
//   it only while the unit is idle.
//   Compute sequence, n = effective vertex count: the sink entry is written
//   first, then for each vertex i below the sink (n-1-i) reads of edge and
//   vertex entries in turn plus one row write-back, serial because of the single
//   read port of each RAM. The path walk then reads the next hop from the
//   vertex RAM before each further result word and waits while the receiver
//   stalls; a stalled result word holds in the output register.
//   Reset: an edge clearing pass over all 2^(2*clog2(MAX_VERTICES)) entries
//   (256 at the defaults) runs first, with item_stall high; vertex_count resets to 8.
`default_nettype none

module multistage_graph_shortest_path_unit #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire logic [msp_pkg::OP_W-1:0]         operation,
    input  wire logic [msp_pkg::VIDX_W-1:0]       from_vertex,
    input  wire logic [msp_pkg::VIDX_W-1:0]       to_vertex,
    input  wire logic [msp_pkg::WFIELD_W-1:0]     weight,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic      [msp_pkg::VIDX_W-1:0]       path_vertex,
    output logic      [msp_pkg::COST_W-1:0]       total_cost,
    output logic                                  reachable,
    output logic                                  last,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [msp_pkg::VCOUNT_W-1:0]     vertex_count
);

    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int CW  = WEIGHT_BITS + VW;
    localparam int EW  = WEIGHT_BITS + 1;
    localparam int VDW = 1 + CW + VW;
    localparam int AW  = 2 * VW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SINK = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_NEXT = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [msp_pkg::VCOUNT_W-1:0] vcount_reg, vcount_next;
    logic [VW-1:0]               i_reg, i_next;
    logic [VW-1:0]               j_reg, j_next;
    logic [VW-1:0]               jd_reg, jd_next;
    logic                        pend_reg, pend_next;
    logic                        found_reg, found_next;
    logic [CW-1:0]               best_reg, best_next;
    logic [VW-1:0]               hop_reg, hop_next;
    logic [CW-1:0]               total_reg, total_next;
    logic                        reach_reg, reach_next;
    logic [VW-1:0]               cur_reg, cur_next;
    logic                        res_valid_reg, res_valid_next;
    msp_pkg::result_t            res_reg, res_next;

    logic [NW-1:0]  n_eff;
    logic [VW-1:0]  sink;
    logic           accept;
    logic           in_range;
    logic           res_free;
    logic           fin;
    logic [CW-1:0]  sat_src;

    logic           e_we;
    logic [AW-1:0]  e_waddr;
    logic [EW-1:0]  e_wdata;
    logic [AW-1:0]  e_raddr;
    logic [EW-1:0]  e_rdata;
    logic           e_busy;

    logic           v_we;
    logic [VW-1:0]  v_waddr;
    logic [VDW-1:0] v_wdata;
    logic [VW-1:0]  v_raddr;
    logic [VDW-1:0] v_rdata;

    logic           cand;
    logic [CW-1:0]  cand_cost;
    logic           take;

    msp_edge_store #(
        .ADDR_W (AW),
        .DATA_W (EW)
    ) u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (e_we),
        .wr_addr (e_waddr),
        .wr_data (e_wdata),
        .rd_addr (e_raddr),
        .rd_data (e_rdata),
        .busy    (e_busy)
    );

    msp_vertex_store #(
        .DEPTH  (MAX_VERTICES),
        .ADDR_W (VW),
        .DATA_W (VDW)
    ) u_vertex (
        .clk     (clk),
        .wr_en   (v_we),
        .wr_addr (v_waddr),
        .wr_data (v_wdata),
        .rd_addr (v_raddr),
        .rd_data (v_rdata)
    );

    always_comb
    begin
        if (int'(vcount_reg) < 2)
        begin
            n_eff = NW'(2);
        end
        else if (int'(vcount_reg) > MAX_VERTICES)
        begin
            n_eff = NW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = NW'(vcount_reg);
        end
    end

    assign sink       = VW'(n_eff - NW'(1));
    assign item_stall = (state_reg != ST_IDLE) || e_busy;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;
    assign in_range   = (int'(from_vertex) < MAX_VERTICES) && (int'(to_vertex) < MAX_VERTICES);
    assign res_free   = !res_valid_reg || !result_stall;
    assign fin        = !reach_reg || (cur_reg == sink);
    assign sat_src    = total_reg;

    // candidate from the read issued last cycle
    assign cand      = pend_reg && e_rdata[EW-1] && v_rdata[VDW-1];
    assign cand_cost = CW'(e_rdata[WEIGHT_BITS-1:0]) + v_rdata[VW +: CW];
    assign take      = cand && (!found_reg || (cand_cost < best_reg));

    assign e_waddr = {VW'(from_vertex), VW'(to_vertex)};
    assign e_raddr = {i_reg, j_reg};

    always_comb
    begin
        e_we = 1'b0;
        e_wdata = '0;
        if (accept && in_range)
        begin
            unique case (operation)
                msp_pkg::OP_WRITE:
                begin
                    e_we = 1'b1;
                    e_wdata = {1'b1, WEIGHT_BITS'(weight)};
                end
                msp_pkg::OP_REMOVE:
                begin
                    e_we = 1'b1;
                end
                default:
                begin
                    e_we = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        vcount_next    = (cfg_valid && cfg_ready) ? vertex_count : vcount_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        jd_next        = jd_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        best_next      = best_reg;
        hop_next       = hop_reg;
        total_next     = total_reg;
        reach_next     = reach_reg;
        cur_next       = cur_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;
        v_we           = 1'b0;
        v_waddr        = i_reg;
        v_wdata        = '0;
        v_raddr        = j_reg;

        if (pend_reg)
        begin
            found_next = found_reg || cand;
            if (take)
            begin
                best_next = cand_cost;
                hop_next  = jd_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == msp_pkg::OP_COMPUTE))
                begin
                    state_next = ST_SINK;
                end
            end
            ST_SINK:
            begin
                v_we       = 1'b1;
                v_waddr    = sink;
                v_wdata    = {1'b1, {CW{1'b0}}, {VW{1'b0}}};
                i_next     = sink - VW'(1);
                j_next     = sink;
                found_next = 1'b0;
                best_next  = '0;
                hop_next   = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                v_raddr   = j_reg;
                pend_next = 1'b1;
                jd_next   = j_reg;
                j_next    = j_reg + VW'(1);
                if (j_reg == sink)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // write back row result before the next row reads it
                v_we       = 1'b1;
                v_waddr    = i_reg;
                v_wdata    = {found_next, found_next ? best_next : {CW{1'b0}}, hop_next};
                found_next = 1'b0;
                best_next  = '0;
                hop_next   = '0;
                if (i_reg == '0)
                begin
                    total_next = (found_reg || cand) ?
                                 (take ? cand_cost : best_reg) : {CW{1'b0}};
                    reach_next = found_reg || cand;
                    cur_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    i_next     = i_reg - VW'(1);
                    j_next     = i_reg;
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                v_raddr = cur_reg;
                if (res_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.path_vertex = msp_pkg::VIDX_W'(cur_reg);
                    res_next.total_cost  =
                        (64'(sat_src) > 64'(msp_pkg::COST_FIELD_MAX)) ?
                        msp_pkg::COST_FIELD_MAX : msp_pkg::COST_W'(sat_src);
                    res_next.reachable   = reach_reg;
                    res_next.last        = fin;
                    state_next = fin ? ST_IDLE : ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                cur_next   = v_rdata[VW-1:0];
                state_next = ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= msp_pkg::VCOUNT_RESET;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            reach_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            reach_reg     <= reach_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        jd_reg    <= jd_next;
        best_reg  <= best_next;
        hop_reg   <= hop_next;
        total_reg <= total_next;
        cur_reg   <= cur_next;
        res_reg   <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign path_vertex  = res_reg.path_vertex;
    assign total_cost   = res_reg.total_cost;
    assign reachable    = res_reg.reachable;
    assign last         = res_reg.last;

endmodule

`default_nettype wire

>>> hdl/msp_edge_store.sv
// Adjacency matrix store: one synchronous RAM of {valid, weight} entries.
// Sweeps every entry to no-edge after reset. Depends on nothing.
`default_nettype none

module msp_edge_store #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 17
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    output logic                   busy
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              busy_reg;
    logic              busy_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
        mem_we    = busy_reg ? 1'b1 : wr_en;
        mem_waddr = busy_reg ? clr_addr_reg : wr_addr;
        mem_wdata = busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[rd_addr];
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> hdl/msp_vertex_store.sv
// Per-vertex table: one synchronous RAM of {valid, cost, next hop}.
// One write port, one registered read port. Depends on nothing.
`default_nettype none

module msp_vertex_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 25
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
